@@ sv/tqa_pkg.sv @@
// ----------------------------------------------------------------------------
// tqa_pkg
// Shared types, codes and sizes for the tagged queue ID allocator.
// ----------------------------------------------------------------------------
package tqa_pkg;

  // Table geometry
  localparam int NUM_QUEUES = 32;
  localparam int TAG_BITS   = 32;
  localparam int COUNT_BITS = 8;
  localparam int IDX_W      = $clog2(NUM_QUEUES);

  // Field widths fixed by the interface
  localparam int TAG_IN_W   = 32;
  localparam int TAG_W      = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int RATE_W     = 24;
  localparam int MARK_W     = 32;
  localparam int OFS_W      = 7;
  localparam int HWQ_W      = 8;
  localparam int QIDX_W     = 6;
  localparam int GIDX_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int REC_W      = COUNT_BITS + 2 * RATE_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [QIDX_W:0]       QUEUE_LIMIT = (QIDX_W + 1)'(NUM_QUEUES);
  localparam logic [IDX_W-1:0]      LAST_IDX    = IDX_W'(NUM_QUEUES - 1);

  // Configuration reset values
  localparam logic [RATE_W-1:0] DEFAULT_RATE_RST = RATE_W'(2500000);
  localparam logic [MARK_W-1:0] MARK_BASE_RST    = 32'h4400_0000;
  localparam logic [OFS_W-1:0]  HWQ_OFFSET_RST   = OFS_W'(16);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HWQ_OFFSET   = 2'd2;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_APPLY   = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_IDX  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0] default_rate;
    logic [MARK_W-1:0] mark_base;
    logic [OFS_W-1:0]  hwq_offset;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic                tag_present;
    logic [TAG_IN_W-1:0] tag_key;
    logic [QIDX_W-1:0]   queue_index;
    logic [RATE_W-1:0]   bandwidth;
    logic [RATE_W-1:0]   bandwidth_ceiling;
  } req_t;

  // One entry of the record memory
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [RATE_W-1:0]     floor_rate;
    logic [RATE_W-1:0]     peak_rate;
  } rec_t;

  typedef struct packed {
    status_t           status;
    logic [GIDX_W-1:0] granted_index;
    logic [MARK_W-1:0] packet_mark;
    logic [HWQ_W-1:0]  hw_queue_number;
    logic [RATE_W-1:0] min_rate_out;
    logic [RATE_W-1:0] max_rate_out;
    logic              reset_issued;
  } result_t;

endpackage

@@ sv/tqa_ram.sv @@
// ----------------------------------------------------------------------------
// tqa_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tqa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tqa_ctrl.sv @@
// ----------------------------------------------------------------------------
// tqa_ctrl
// Sequencer for the allocator: tag scan over the tag memory, free-entry
// search over the in-use flags, read-modify-write of the record memory.
// ----------------------------------------------------------------------------
module tqa_ctrl import tqa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  req_t                  req_in,
  input  cfg_t                  cfg,
  output logic                  busy,
  // tag memory
  output logic [IDX_W-1:0]      tag_raddr,
  input  logic [TAG_W-1:0]      tag_rdata,
  output logic                  tag_we,
  output logic [IDX_W-1:0]      tag_waddr,
  output logic [TAG_W-1:0]      tag_wdata,
  // record memory
  output logic [IDX_W-1:0]      rec_raddr,
  input  rec_t                  rec_rdata,
  output logic                  rec_we,
  output logic [IDX_W-1:0]      rec_waddr,
  output rec_t                  rec_wdata,
  // result
  output logic                  done,
  output result_t               res
);

  state_t state, state_next;
  req_t   req;

  logic [NUM_QUEUES-1:0] in_use;
  logic [NUM_QUEUES-1:0] tag_valid;

  logic [IDX_W-1:0] entry, entry_next;
  logic             joined, joined_next;

  // scan pipeline
  logic [IDX_W-1:0] scan_idx;
  logic             issue_done;
  logic             pend_vld;
  logic [IDX_W-1:0] pend_idx;

  logic             done_next;
  result_t          res_next;
  logic             set_use, clr_use;

  logic             is_acq, tag_path, bad_idx, free_any, hit, scan_end;
  logic [IDX_W-1:0] free_idx;
  logic [TAG_W-1:0] key;

  // lowest entry with a zero count
  function automatic logic [IDX_W-1:0] first_free(input logic [NUM_QUEUES-1:0] use_vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!use_vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign busy = (state != ST_IDLE);

  // request decode
  assign key      = req.tag_key[TAG_W-1:0];
  assign is_acq   = (req.mode == MODE_ACQUIRE);
  assign tag_path = req.tag_present && (|tag_valid);
  assign bad_idx  = (req.mode == MODE_UNUSED) ||
                    ({1'b0, req.queue_index} >= QUEUE_LIMIT) ||
                    !in_use[req.queue_index[IDX_W-1:0]];
  assign free_any = !(&in_use);
  assign free_idx = first_free(in_use);
  assign hit      = pend_vld && tag_valid[pend_idx] && (tag_rdata == key);
  assign scan_end = pend_vld && (pend_idx == LAST_IDX);

  assign tag_raddr = scan_idx;
  assign rec_raddr = entry;
  assign tag_waddr = entry;
  assign rec_waddr = entry;
  assign tag_wdata = key;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (is_acq) begin
          if (tag_path) begin
            state_next = ST_SCAN;
          end else begin
            state_next = free_any ? ST_READ : ST_IDLE;
          end
        end else begin
          state_next = bad_idx ? ST_IDLE : ST_READ;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_READ;
        end else if (scan_end) begin
          state_next = free_any ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // target entry selection
  always_comb begin
    entry_next  = entry;
    joined_next = joined;
    unique case (state)
      ST_DECIDE: begin
        joined_next = 1'b0;
        entry_next  = is_acq ? free_idx : req.queue_index[IDX_W-1:0];
      end
      ST_SCAN: begin
        joined_next = hit;
        entry_next  = hit ? pend_idx : free_idx;
      end
      default: begin
      end
    endcase
  end

  // results and memory writes
  always_comb begin
    logic [COUNT_BITS-1:0] cnt_dec;
    done_next = 1'b0;
    res_next  = '0;
    tag_we    = 1'b0;
    rec_we    = 1'b0;
    rec_wdata = rec_rdata;
    set_use   = 1'b0;
    clr_use   = 1'b0;
    cnt_dec   = rec_rdata.count - 1'b1;
    unique case (state)
      ST_DECIDE: begin
        if (is_acq && !tag_path && !free_any) begin
          done_next       = 1'b1;
          res_next.status = STAT_FULL;
        end else if (!is_acq && bad_idx) begin
          done_next              = 1'b1;
          res_next.status        = STAT_BAD_IDX;
          res_next.granted_index = req.queue_index[GIDX_W-1:0];
        end
      end
      ST_SCAN: begin
        if (!hit && scan_end && !free_any) begin
          done_next       = 1'b1;
          res_next.status = STAT_FULL;
        end
      end
      ST_EXEC: begin
        done_next              = 1'b1;
        res_next.granted_index = GIDX_W'(entry);
        res_next.hw_queue_number = HWQ_W'(cfg.hwq_offset) + HWQ_W'(entry);
        unique case (req.mode)
          MODE_ACQUIRE: begin
            if (joined && rec_rdata.count == COUNT_MAX) begin
              // saturated share count, nothing changes
              res_next.status          = STAT_OVERFLOW;
              res_next.hw_queue_number = '0;
            end else begin
              rec_we          = 1'b1;
              set_use         = 1'b1;
              tag_we          = !joined && req.tag_present;
              rec_wdata.count = joined ? rec_rdata.count + 1'b1 : COUNT_BITS'(1);
              if (req.bandwidth_ceiling != '0) begin
                rec_wdata.peak_rate  = req.bandwidth_ceiling;
                rec_wdata.floor_rate = req.bandwidth;
              end else begin
                rec_wdata.peak_rate  = req.bandwidth;
                rec_wdata.floor_rate = '0;
              end
              res_next.status       = STAT_OK;
              res_next.packet_mark  = cfg.mark_base | MARK_W'(entry);
              res_next.min_rate_out = rec_wdata.floor_rate;
              res_next.max_rate_out = rec_wdata.peak_rate;
            end
          end
          MODE_RELEASE: begin
            rec_we          = 1'b1;
            rec_wdata.count = cnt_dec;
            res_next.status = STAT_OK;
            if (cnt_dec == '0) begin
              // last reference: free entry, fall back to default rate
              clr_use               = 1'b1;
              res_next.reset_issued = 1'b1;
              res_next.max_rate_out = cfg.default_rate;
            end
          end
          MODE_APPLY: begin
            res_next.status       = STAT_OK;
            res_next.min_rate_out = rec_rdata.floor_rate;
            res_next.max_rate_out = rec_rdata.peak_rate;
          end
          MODE_UNUSED: begin
            // filtered out in the decide step
            res_next.status = STAT_BAD_IDX;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      in_use    <= '0;
      tag_valid <= '0;
      pend_vld  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (set_use) begin
        in_use[entry] <= 1'b1;
        if (!joined) begin
          tag_valid[entry] <= req.tag_present;
        end
      end
      if (clr_use) begin
        in_use[entry]    <= 1'b0;
        tag_valid[entry] <= 1'b0;
      end
      pend_vld <= (state == ST_SCAN) && !issue_done && !hit;
    end
  end

  // request, entry and scan address registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req <= req_in;
    end
    entry  <= entry_next;
    joined <= joined_next;
    if (done_next) begin
      res <= res_next;
    end
    if (state == ST_DECIDE) begin
      scan_idx   <= '0;
      issue_done <= 1'b0;
    end else if (state == ST_SCAN && !issue_done) begin
      pend_idx <= scan_idx;
      if (scan_idx == LAST_IDX) begin
        issue_done <= 1'b1;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

endmodule

@@ sv/tagged_queue_id_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tagged_queue_id_allocator_unit
// Reference-counted traffic queue allocator with shareable tagged entries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive mode and the request fields with start; the
//   transaction is taken at a clock edge where start is high and busy low.
//   Result channel: done is high for exactly one cycle with status, index,
//   mark, hardware queue number and rates; the receiver must take it then.
//   Config port: cfg_write with cfg_index/cfg_data writes one register;
//   write only while busy is low and no result is pending.
// Sequencing:
//   Release, apply and untagged acquire: done follows the accepting edge
//   through decide, record read, execute and the result register.
//   Bad index or table full: decide, then the result register.
//   Tagged acquire walks the tag memory one entry a cycle, stopping at the
//   first tag hit or after the last entry.
//   busy drops in the cycle done is shown, so the next command can be taken
//   then. One command is processed at a time.
// Reset: all entries free, config registers at their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module tagged_queue_id_allocator_unit import tqa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic                  tag_present,
  input  logic [TAG_IN_W-1:0]   tag_key,
  input  logic [QIDX_W-1:0]     queue_index,
  input  logic [RATE_W-1:0]     bandwidth,
  input  logic [RATE_W-1:0]     bandwidth_ceiling,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                  done,
  output logic [1:0]            status,
  output logic [GIDX_W-1:0]     granted_index,
  output logic [MARK_W-1:0]     packet_mark,
  output logic [HWQ_W-1:0]      hw_queue_number,
  output logic [RATE_W-1:0]     min_rate_out,
  output logic [RATE_W-1:0]     max_rate_out,
  output logic                  reset_issued
);

  cfg_t             cfg;
  req_t             req_in;
  result_t          res;

  logic [IDX_W-1:0] tag_raddr, tag_waddr, rec_raddr, rec_waddr;
  logic [TAG_W-1:0] tag_rdata, tag_wdata;
  logic             tag_we, rec_we;
  rec_t             rec_rdata, rec_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_rate <= DEFAULT_RATE_RST;
      cfg.mark_base    <= MARK_BASE_RST;
      cfg.hwq_offset   <= HWQ_OFFSET_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEFAULT_RATE: cfg.default_rate <= cfg_data[RATE_W-1:0];
        CFG_MARK_BASE:    cfg.mark_base    <= cfg_data[MARK_W-1:0];
        CFG_HWQ_OFFSET:   cfg.hwq_offset   <= cfg_data[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // command bundle
  always_comb begin
    req_in.mode              = mode_t'(mode);
    req_in.tag_present       = tag_present;
    req_in.tag_key           = tag_key;
    req_in.queue_index       = queue_index;
    req_in.bandwidth         = bandwidth;
    req_in.bandwidth_ceiling = bandwidth_ceiling;
  end

  // tag keys of live entries
  tqa_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_QUEUES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // reference count and stored rates
  tqa_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_QUEUES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  tqa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req_in),
    .cfg       (cfg),
    .busy      (busy),
    .tag_raddr (tag_raddr),
    .tag_rdata (tag_rdata),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_wdata),
    .rec_raddr (rec_raddr),
    .rec_rdata (rec_rdata),
    .rec_we    (rec_we),
    .rec_waddr (rec_waddr),
    .rec_wdata (rec_wdata),
    .done      (done),
    .res       (res)
  );

  // result fields
  assign status          = res.status;
  assign granted_index   = res.granted_index;
  assign packet_mark     = res.packet_mark;
  assign hw_queue_number = res.hw_queue_number;
  assign min_rate_out    = res.min_rate_out;
  assign max_rate_out    = res.max_rate_out;
  assign reset_issued    = res.reset_issued;

endmodule
